// ===== rtl/dpf_pkg.sv =====
package dpf_pkg;

    localparam int KeyWidth        = 32;
    localparam int CoordWidth      = 16;
    localparam int OutCountWidth   = 24;
    localparam int MinSamplesWidth = 16;
    localparam int ShareWidth      = 7;

    localparam logic [ShareWidth-1:0] ShareScale = 7'd100;

    // Configuration port.
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 16;

    localparam logic [CfgIdxWidth-1:0] CfgMinSamples = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgMinShare   = 2'd1;

    localparam logic [MinSamplesWidth-1:0] MinSamplesReset = 16'd8;
    localparam logic [ShareWidth-1:0]      MinShareReset   = 7'd50;

    typedef enum logic [1:0] {
        OpAdd    = 2'd0,
        OpEst    = 2'd1,
        OpFinish = 2'd2,
        OpNone   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic signed [CoordWidth-1:0] pos_x;
        logic signed [CoordWidth-1:0] pos_y;
    } t_req;

    typedef struct packed {
        logic                         is_dominant;
        logic signed [CoordWidth-1:0] anchor_x;
        logic signed [CoordWidth-1:0] anchor_y;
        logic [OutCountWidth-1:0]     best_hits;
        logic [OutCountWidth-1:0]     total_samples;
    } t_res;

    // Control part of the token that walks the cell chain.
    typedef struct packed {
        logic active;
        t_op  op;
        logic done;
    } t_tok_ctl;

    // True when key a orders strictly before key b: signed x, then signed y.
    function automatic logic key_less(input logic [KeyWidth-1:0] a,
                                      input logic [KeyWidth-1:0] b);
        logic [KeyWidth-1:0] ua;
        logic [KeyWidth-1:0] ub;
        ua = {~a[31], a[30:16], ~a[15], a[14:0]};
        ub = {~b[31], b[30:16], ~b[15], b[14:0]};
        return ua < ub;
    endfunction

endpackage

// ===== rtl/dpf_req_if.sv =====
interface dpf_req_if;
    import dpf_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dpf_res_if.sv =====
interface dpf_res_if;
    import dpf_pkg::*;

    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dominant_position_finder.sv =====
// Dominant position finder: a frequency table of signed (x,y) positions.
// Requests arrive on i_req (valid/ready); a request is taken at a clock edge
// with both high. An add request counts one sample; an estimate request and
// a finish request each produce one result on o_res (valid/ready), and a
// finish request also empties the table and the sample total.
// The table is a row of TABLE_DEPTH cells. Each request becomes a token that
// steps through one cell per cycle. An add request holds the block until its
// token leaves the last cell; an estimate or finish request then passes
// StCmp, which waits for a free output register before the result is loaded
// into it and shown on o_res. One request is in work at a time. The result
// sits in the output register; the next request is taken while it waits,
// and only a second result stalls until the first is taken. Reset
// (synchronous, active low) empties the table, clears the total and sets
// min_samples to 8 and min_share_percent to 50. Configuration is written
// through i_cfg_we, i_cfg_idx and i_cfg_wdata; the user must do so only
// while the block is idle, and the block itself does not enforce this.
module dominant_position_finder #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dpf_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [dpf_pkg::CfgDataWidth-1:0] i_cfg_wdata,
    dpf_req_if.sink                          i_req,
    dpf_res_if.source                        o_res
);
    import dpf_pkg::*;

    localparam int ProdWidth = COUNT_WIDTH + ShareWidth;

    typedef enum logic [1:0] {
        StIdle,
        StRun,
        StCmp
    } t_state;

    // Token chain: element i feeds cell i, element TABLE_DEPTH leaves the row.
    t_tok_ctl               w_tok_ctl [TABLE_DEPTH+1];
    logic [KeyWidth-1:0]    w_tok_key [TABLE_DEPTH+1];
    logic [COUNT_WIDTH-1:0] w_tok_cnt [TABLE_DEPTH+1];

    t_state                     r_state;
    t_tok_ctl                   r_inj_ctl;
    logic [KeyWidth-1:0]        r_inj_key;
    logic [COUNT_WIDTH-1:0]     r_total;
    logic [MinSamplesWidth-1:0] r_min_samples;
    logic [ShareWidth-1:0]      r_min_share;
    logic [KeyWidth-1:0]        r_best_key;
    logic [COUNT_WIDTH-1:0]     r_best_cnt;
    logic [ProdWidth-1:0]       r_prod_best;
    logic [ProdWidth-1:0]       r_prod_total;
    logic                       r_finish;
    logic                       r_out_valid;
    t_res                       r_out;

    logic       w_take;
    logic       w_tok_exit;
    logic       w_dominant;
    logic       w_out_free;
    logic [31:0] w_best32;
    logic [31:0] w_total32;

    assign w_take     = i_req.valid && (r_state == StIdle);
    assign w_tok_exit = w_tok_ctl[TABLE_DEPTH].active;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_best32   = 32'(r_best_cnt);
    assign w_total32  = 32'(r_total);
    assign w_dominant = (w_best32 >= 32'(r_min_samples)) && (r_prod_best >= r_prod_total);

    assign w_tok_ctl[0] = r_inj_ctl;
    assign w_tok_key[0] = r_inj_key;
    assign w_tok_cnt[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        dpf_cell #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok_ctl (w_tok_ctl[g]),
            .i_tok_key (w_tok_key[g]),
            .i_tok_cnt (w_tok_cnt[g]),
            .o_tok_ctl (w_tok_ctl[g+1]),
            .o_tok_key (w_tok_key[g+1]),
            .o_tok_cnt (w_tok_cnt[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= StIdle;
            r_inj_ctl.active <= 1'b0;
            r_total          <= '0;
            r_min_samples    <= MinSamplesReset;
            r_min_share      <= MinShareReset;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgMinSamples: r_min_samples <= i_cfg_wdata[MinSamplesWidth-1:0];
                    CfgMinShare:   r_min_share   <= i_cfg_wdata[ShareWidth-1:0];
                    default: begin
                    end
                endcase
            end

            r_inj_ctl.active <= 1'b0;
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                StIdle: begin
                    // An unused request code is taken and dropped.
                    if (w_take && (t_op'(i_req.payload.req_type) != OpNone)) begin
                        r_inj_ctl.active <= 1'b1;
                        r_state          <= StRun;
                    end
                end
                StRun: begin
                    if (w_tok_exit) begin
                        if (w_tok_ctl[TABLE_DEPTH].op == OpAdd) begin
                            // A sample that found no entry and no free cell is lost.
                            if (w_tok_ctl[TABLE_DEPTH].done && !(&r_total)) begin
                                r_total <= r_total + COUNT_WIDTH'(1);
                            end
                            r_state <= StIdle;
                        end else begin
                            r_state <= StCmp;
                        end
                    end
                end
                StCmp: begin
                    // Hold the finished estimate until the output register frees up.
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_finish) begin
                            r_total <= '0;
                        end
                        r_state <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end

        // Payload registers.
        if (w_take) begin
            r_inj_ctl.op   <= t_op'(i_req.payload.req_type);
            r_inj_ctl.done <= 1'b0;
            if (t_op'(i_req.payload.req_type) == OpAdd) begin
                r_inj_key <= {i_req.payload.pos_x, i_req.payload.pos_y};
            end else begin
                r_inj_key <= '0;
            end
        end
        if ((r_state == StRun) && w_tok_exit) begin
            r_best_key   <= w_tok_key[TABLE_DEPTH];
            r_best_cnt   <= w_tok_cnt[TABLE_DEPTH];
            r_prod_best  <= ProdWidth'(w_tok_cnt[TABLE_DEPTH]) * ProdWidth'(ShareScale);
            r_prod_total <= ProdWidth'(r_total) * ProdWidth'(r_min_share);
            r_finish     <= (w_tok_ctl[TABLE_DEPTH].op == OpFinish);
        end
        if ((r_state == StCmp) && w_out_free) begin
            r_out.is_dominant   <= w_dominant;
            r_out.anchor_x      <= w_dominant ? r_best_key[31:16] : '0;
            r_out.anchor_y      <= w_dominant ? r_best_key[15:0] : '0;
            r_out.best_hits     <= w_best32[OutCountWidth-1:0];
            r_out.total_samples <= w_total32[OutCountWidth-1:0];
        end
    end

    assign i_req.ready   = (r_state == StIdle);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

// ===== rtl/dpf_cell.sv =====
module dpf_cell #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dpf_pkg::t_tok_ctl            i_tok_ctl,
    input  logic [dpf_pkg::KeyWidth-1:0] i_tok_key,
    input  logic [COUNT_WIDTH-1:0]       i_tok_cnt,
    output dpf_pkg::t_tok_ctl            o_tok_ctl,
    output logic [dpf_pkg::KeyWidth-1:0] o_tok_key,
    output logic [COUNT_WIDTH-1:0]       o_tok_cnt
);
    import dpf_pkg::*;

    logic                   r_valid;
    logic [KeyWidth-1:0]    r_key;
    logic [COUNT_WIDTH-1:0] r_cnt;
    t_tok_ctl               r_tok_ctl;
    logic [KeyWidth-1:0]    r_tok_key;
    logic [COUNT_WIDTH-1:0] r_tok_cnt;

    logic                   n_valid;
    logic [KeyWidth-1:0]    n_key;
    logic [COUNT_WIDTH-1:0] n_cnt;
    t_tok_ctl               n_tok_ctl;
    logic [KeyWidth-1:0]    n_tok_key;
    logic [COUNT_WIDTH-1:0] n_tok_cnt;

    always_comb begin
        n_valid   = r_valid;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_tok_ctl = i_tok_ctl;
        n_tok_key = i_tok_key;
        n_tok_cnt = i_tok_cnt;
        if (i_tok_ctl.active) begin
            case (i_tok_ctl.op) inside
                OpAdd: begin
                    // Entries fill from the front, so the first free cell is
                    // reached only after every valid entry has been checked.
                    if (!i_tok_ctl.done) begin
                        if (r_valid) begin
                            if (r_key == i_tok_key) begin
                                n_cnt          = (&r_cnt) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
                                n_tok_ctl.done = 1'b1;
                            end
                        end else begin
                            n_valid        = 1'b1;
                            n_key          = i_tok_key;
                            n_cnt          = COUNT_WIDTH'(1);
                            n_tok_ctl.done = 1'b1;
                        end
                    end
                end
                OpEst, OpFinish: begin
                    if (r_valid && ((r_cnt > i_tok_cnt) ||
                                    ((r_cnt == i_tok_cnt) && (i_tok_cnt != '0) &&
                                     key_less(r_key, i_tok_key)))) begin
                        n_tok_key = r_key;
                        n_tok_cnt = r_cnt;
                    end
                    if (i_tok_ctl.op == OpFinish) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid          <= 1'b0;
            r_tok_ctl.active <= 1'b0;
        end else begin
            r_valid          <= n_valid;
            r_tok_ctl.active <= n_tok_ctl.active;
        end
        r_key          <= n_key;
        r_cnt          <= n_cnt;
        r_tok_ctl.op   <= n_tok_ctl.op;
        r_tok_ctl.done <= n_tok_ctl.done;
        r_tok_key      <= n_tok_key;
        r_tok_cnt      <= n_tok_cnt;
    end

    assign o_tok_ctl = r_tok_ctl;
    assign o_tok_key = r_tok_key;
    assign o_tok_cnt = r_tok_cnt;

endmodule

// ===== sim/dominant_position_finder_checker.sv =====
module dominant_position_finder_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dpf_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [dpf_pkg::CfgDataWidth-1:0] i_cfg_wdata,
    dpf_req_if                               req_mon,
    dpf_res_if                               res_mon,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpf_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] HitsMax = '1;

    logic [KeyWidth-1:0]        pos_key  [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]     pos_hits [TABLE_DEPTH];
    logic                       pos_live [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]     sample_sum;
    logic [MinSamplesWidth-1:0] need_hits;
    logic [ShareWidth-1:0]      need_share;
    t_res                       mode_q[$];
    int                         fails;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == HitsMax) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Signed x decides first, signed y breaks the tie.
    function automatic logic orders_first(input logic [KeyWidth-1:0] a,
                                          input logic [KeyWidth-1:0] b);
        logic signed [CoordWidth-1:0] ax;
        logic signed [CoordWidth-1:0] bx;
        logic signed [CoordWidth-1:0] ay;
        logic signed [CoordWidth-1:0] by;
        ax = a[31:16];
        bx = b[31:16];
        ay = a[15:0];
        by = b[15:0];
        if (ax != bx) return ax < bx;
        return ay < by;
    endfunction

    task automatic clear_positions();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            pos_live[i] = 1'b0;
            pos_key[i]  = '0;
            pos_hits[i] = '0;
        end
        sample_sum = '0;
    endtask

    // Append one expected result behind those still outstanding.
    task automatic enqueue_mode(input t_res res);
        mode_q = {mode_q, res};
    endtask

    // A known position is bumped; a new one takes the first free slot, and is
    // dropped without touching the total when the table is full.
    task automatic log_sample(input logic [KeyWidth-1:0] key);
        int slot;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (pos_live[i]) begin
                if (pos_key[i] == key) begin
                    pos_hits[i] = bump(pos_hits[i]);
                    sample_sum  = bump(sample_sum);
                    return;
                end
            end else if (slot < 0) begin
                slot = i;
            end
        end
        if (slot < 0) return;
        pos_live[slot] = 1'b1;
        pos_key[slot]  = key;
        pos_hits[slot] = bump('0);
        sample_sum     = bump(sample_sum);
    endtask

    function automatic t_res mode_estimate();
        logic [COUNT_WIDTH-1:0] top_hits;
        logic [KeyWidth-1:0]    top_key;
        logic                   dom;
        longint unsigned        lhs;
        longint unsigned        rhs;
        t_res                   res;
        top_hits = '0;
        top_key  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (pos_live[i] && (pos_hits[i] > top_hits ||
                (pos_hits[i] == top_hits && top_hits != '0 &&
                 orders_first(pos_key[i], top_key)))) begin
                top_hits = pos_hits[i];
                top_key  = pos_key[i];
            end
        end
        lhs = 64'(top_hits) * 64'(ShareScale);
        rhs = 64'(sample_sum) * 64'(need_share);
        dom = (top_hits >= need_hits) && (lhs >= rhs);
        res.is_dominant   = dom;
        res.anchor_x      = dom ? top_key[31:16] : '0;
        res.anchor_y      = dom ? top_key[15:0] : '0;
        res.best_hits     = OutCountWidth'(top_hits);
        res.total_samples = OutCountWidth'(sample_sum);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            clear_positions();
            need_hits  = MinSamplesReset;
            need_share = MinShareReset;
            mode_q.delete();
            fails = 0;
        end else begin
            // A result always belongs to an older request, so it is matched
            // before any request taken at the same edge is predicted.
            if (res_mon.valid && res_mon.ready) begin
                got = res_mon.payload;
                if (mode_q.size() == 0) begin
                    $error("result with nothing outstanding: %0h", got);
                    fails++;
                end else begin
                    want = mode_q.pop_front();
                    compare_field("is_dominant", 32'(want.is_dominant), 32'(got.is_dominant));
                    compare_field("anchor_x", 32'(want.anchor_x), 32'(got.anchor_x));
                    compare_field("anchor_y", 32'(want.anchor_y), 32'(got.anchor_y));
                    compare_field("best_hits", 32'(want.best_hits), 32'(got.best_hits));
                    compare_field("total_samples", 32'(want.total_samples),
                                  32'(got.total_samples));
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                case (t_op'(req_mon.payload.req_type))
                    OpAdd: begin
                        log_sample({req_mon.payload.pos_x, req_mon.payload.pos_y});
                    end
                    OpEst: begin
                        enqueue_mode(mode_estimate());
                    end
                    OpFinish: begin
                        enqueue_mode(mode_estimate());
                        clear_positions();
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgMinSamples: need_hits = i_cfg_wdata;
                    CfgMinShare:   need_share = i_cfg_wdata[ShareWidth-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= mode_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/dominant_position_finder_tb.sv =====
module dominant_position_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dpf_pkg::*;

    localparam int TableDepth = 64;
    localparam int CountWidth = 24;
    // A request's token has to pass all TableDepth cells; the extra
    // margin also covers a result that waits out the longest sink stall.
    localparam int DrainCycles = TableDepth + 16;
    localparam int MaxIdle     = 12;
    localparam int PhaseCount  = 12;
    localparam int PhaseItems  = 80;
    localparam int PoolMax     = 96;

    // Indexes past the two real registers; writes to them must be ignored.
    localparam logic [CfgIdxWidth-1:0] CfgSpareLo = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CfgSpareHi = 2'd3;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_idx;
    logic [CfgDataWidth-1:0] cfg_wdata;
    int                      fail_count;
    int                      pending;
    bit                      no_idle;

    dpf_req_if req_if ();
    dpf_res_if res_if ();

    dominant_position_finder #(
        .TABLE_DEPTH (TableDepth),
        .COUNT_WIDTH (CountWidth)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // The checker sits beside the block, watches both channels and the
    // configuration port, and reports its failure count and how many
    // results it still waits for.
    dominant_position_finder_checker #(
        .TABLE_DEPTH (TableDepth),
        .COUNT_WIDTH (CountWidth)
    ) u_mode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .req_mon      (req_if),
        .res_mon      (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Both sides draw a fresh idle count per request or result; some phases switch
    // idling off so that back-to-back traffic is covered as well.
    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(MaxIdle, 0);
    endfunction

    // Result side: drop ready for a random number of cycles, then hold it
    // high until one result has been taken.
    initial begin
        int n;
        forever begin
            n = idle_draw();
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // Offer one request after a random gap and return at the edge where it
    // is taken. Valid stays high on return, so a following request with no
    // gap goes out back to back.
    task automatic send_request(input t_op op, input logic [CoordWidth-1:0] x,
                                input logic [CoordWidth-1:0] y);
        int n;
        n = idle_draw();
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= {op, x, y};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic add_sample_at(input logic [KeyWidth-1:0] key);
        send_request(OpAdd, key[31:16], key[15:0]);
    endtask

    // Stop offering requests and wait until every estimate has come back.
    // An add request gives no result, so the block may still be busy with
    // one; the extra cycles let it finish before anything else happens.
    task automatic settle_block();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Registers are only written once the block is idle. The share value is
    // written at full port width so the upper bits that the block masks off
    // get exercised too.
    task automatic write_config(input logic [CfgDataWidth-1:0] min_val,
                                input logic [CfgDataWidth-1:0] share_raw,
                                input bit touch_spare);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_idx   <= CfgMinSamples;
        cfg_wdata <= min_val;
        @(posedge i_clk);
        cfg_idx   <= CfgMinShare;
        cfg_wdata <= share_raw;
        @(posedge i_clk);
        if (touch_spare) begin
            cfg_idx   <= CfgSpareLo;
            cfg_wdata <= CfgDataWidth'($urandom);
            @(posedge i_clk);
            cfg_idx   <= CfgSpareHi;
            cfg_wdata <= CfgDataWidth'($urandom);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [KeyWidth-1:0]        pool [PoolMax];
        logic [KeyWidth-1:0]        key;
        logic [MinSamplesWidth-1:0] min_val;
        logic [CfgDataWidth-1:0]    share_raw;
        int                         pool_size;
        int                         fin_limit;
        int                         r;
        bit                         wide;

        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= '0;
        cfg_wdata      <= '0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        no_idle        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the reset settings. An empty table gives
        // a zero best count, and the unused request code must do nothing.
        send_request(OpEst, '0, '0);
        send_request(OpFinish, '0, '0);
        send_request(OpNone, CoordWidth'($urandom), CoordWidth'($urandom));
        send_request(OpEst, '0, '0);

        // Coordinate extremes, then a tie between the most negative and the
        // most positive corners: the smaller key has to win.
        add_sample_at({16'sh8000, 16'sh8000});
        add_sample_at({16'sh7fff, 16'sh7fff});
        add_sample_at({16'sh0000, 16'sh0000});
        add_sample_at({16'shffff, 16'sh0000});
        add_sample_at({16'sh7fff, 16'sh8000});
        add_sample_at({16'sh8000, 16'sh7fff});
        add_sample_at({16'sh8000, 16'sh8000});
        send_request(OpEst, '0, '0);
        add_sample_at({16'sh7fff, 16'sh7fff});
        send_request(OpEst, '0, '0);
        // Same x, y decides the tie.
        add_sample_at({16'sh8000, 16'sh7fff});
        send_request(OpFinish, '0, '0);
        send_request(OpEst, '0, '0);

        // Zero thresholds: even the empty table counts as dominant, and the
        // anchor is then the origin.
        write_config('0, '0, 1'b0);
        send_request(OpEst, '0, '0);
        add_sample_at({16'sh1234, 16'shedcb});
        add_sample_at({16'sh1234, 16'shedcb});
        send_request(OpFinish, '0, '0);

        // Largest thresholds; all ones on the share port masks to 127, a
        // share above 100 that no position can meet.
        write_config('1, '1, 1'b1);
        add_sample_at({16'sh0001, 16'shffff});
        send_request(OpEst, '0, '0);

        // Random phases. Each phase draws its own thresholds and a pool of
        // positions. Narrow pools give repeated hits, ties and a dominant
        // position; wide pools hold more distinct positions than the table,
        // so the later new positions are dropped.
        for (int phase = 0; phase < PhaseCount; phase++) begin
            case ($urandom_range(4, 0))
                0:       min_val = '0;
                1:       min_val = '1;
                default: min_val = MinSamplesWidth'($urandom_range(12, 0));
            endcase
            case ($urandom_range(5, 0))
                0:       share_raw = '0;
                1:       share_raw = CfgDataWidth'(ShareScale);
                2:       share_raw = CfgDataWidth'($urandom);
                default: share_raw = CfgDataWidth'($urandom_range(100, 0));
            endcase
            write_config(min_val, share_raw, phase == PhaseCount - 1);
            no_idle = (phase % 4 == 3);

            wide = (phase % 3 == 0);
            if (wide) begin
                pool_size = $urandom_range(PoolMax, TableDepth + 8);
                fin_limit = 98;
            end else begin
                pool_size = $urandom_range(10, 1);
                fin_limit = 96;
            end
            for (int i = 0; i < pool_size; i++) begin
                if (!wide && $urandom_range(1, 0) == 0) begin
                    pool[i] = {16'(int'($urandom_range(8, 0)) - 4),
                               16'(int'($urandom_range(8, 0)) - 4)};
                end else begin
                    pool[i] = $urandom;
                end
            end

            for (int k = 0; k < PhaseItems; k++) begin
                r = $urandom_range(99, 0);
                if (r < 84) begin
                    // The first pool entry is favored so that one position
                    // tends to dominate the rest.
                    if ($urandom_range(9, 0) < 4) key = pool[0];
                    else key = pool[$urandom_range(pool_size - 1, 0)];
                    add_sample_at(key);
                end else if (r < 93) begin
                    send_request(OpEst, CoordWidth'($urandom), CoordWidth'($urandom));
                end else if (r < fin_limit) begin
                    send_request(OpFinish, CoordWidth'($urandom), CoordWidth'($urandom));
                end else begin
                    send_request(OpNone, CoordWidth'($urandom), CoordWidth'($urandom));
                end
            end
            send_request(OpEst, '0, '0);
        end

        // Let the last results come back and the block go quiet before the
        // verdict.
        no_idle = 1'b0;
        settle_block();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
